FILE: hw/rtl/rcfs_pkg.sv
// shared types and constants for the rc failsafe tank drive mixer
`default_nettype none

package rcfs_pkg;

    localparam int WIDTH_W    = 15;
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIMIT    = 2'd3;

    // configuration reset values
    localparam logic [WIDTH_W-1:0] PULSE_MIN_RST    = 15'd1000;
    localparam logic [WIDTH_W-1:0] PULSE_MAX_RST    = 15'd2000;
    localparam logic [TIME_W-1:0]  FRESH_WINDOW_RST = 32'd100000;
    localparam logic [COUNT_W-1:0] BAD_LIMIT_RST    = 8'd10;

    typedef enum logic [1:0] {
        LINK_LOST  = 2'd0,
        LINK_DRIVE = 2'd1,
        LINK_HOLD  = 2'd2
    } t_link_status;

    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_min;
        logic [WIDTH_W-1:0] pulse_max;
        logic [TIME_W-1:0]  fresh_window;
        logic [COUNT_W-1:0] bad_limit;
    } t_cfg;

    typedef struct packed {
        t_link_status       status;
        logic [COUNT_W-1:0] bad_run;
    } t_link_dec;

    typedef struct packed {
        logic [DUTY_W-1:0] left_fwd;
        logic [DUTY_W-1:0] left_rev;
        logic [DUTY_W-1:0] right_fwd;
        logic [DUTY_W-1:0] right_rev;
    } t_duties;

endpackage

`default_nettype wire

FILE: hw/rtl/rc_failsafe_tank_drive_mixer.sv
// top level of the rc failsafe tank drive mixer: handshake, config and result registers
`default_nettype none

// usage
//  - input channel: i_valid / o_stall with one port per field; a word is taken at a
//    rising edge where i_valid is high and o_stall is low
//  - output channel: o_valid / i_stall; a word leaves at an edge where o_valid is high
//    and i_stall is low
//  - config: write i_cfg_data to register i_cfg_idx at an edge with i_cfg_wr_en high,
//    only while the block is idle; no read-back
//  - a taken word sits in the input register, then moves to the result register on the outputs
//  - throughput: one word per cycle while i_stall is low, the state update being a single
//    pass through the capture, link and mix logic between the input and result registers
//  - while the receiver stalls, the result register holds and one further word can sit
//    in the input register; o_stall rises only when both are full
//  - reset (synchronous, active low) empties both registers, clears held pulses, times,
//    the bad counter and the held duties, and restores the register defaults
//  - link lost, also on stale input, zeroes all duties; bad widths hold the last duties
module rc_failsafe_tank_drive_mixer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [rcfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rcfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [rcfs_pkg::TIME_W-1:0]     i_now_us,
    input  wire logic [rcfs_pkg::WIDTH_W-1:0]    i_steer_width_us,
    input  wire logic [rcfs_pkg::WIDTH_W-1:0]    i_throttle_width_us,
    input  wire logic                            i_obstacle_front_right,
    input  wire logic                            i_obstacle_front_left,
    input  wire logic                            i_obstacle_rear_right,
    input  wire logic                            i_obstacle_rear_left,
    // output channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [rcfs_pkg::DUTY_W-1:0]     o_left_forward_duty,
    output logic      [rcfs_pkg::DUTY_W-1:0]     o_left_reverse_duty,
    output logic      [rcfs_pkg::DUTY_W-1:0]     o_right_forward_duty,
    output logic      [rcfs_pkg::DUTY_W-1:0]     o_right_reverse_duty,
    output logic      [1:0]                      o_link_status,
    output logic      [rcfs_pkg::COUNT_W-1:0]    o_bad_run
);
    import rcfs_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic               r_in_valid;
    logic [TIME_W-1:0]  r_in_now;
    logic [WIDTH_W-1:0] r_in_steer;
    logic [WIDTH_W-1:0] r_in_thr;
    logic               r_in_fr, r_in_fl, r_in_rr, r_in_rl;

    // result register
    logic               r_out_valid;
    t_duties            r_out_duties;
    t_link_status       r_out_status;
    logic [COUNT_W-1:0] r_out_bad;

    // duties kept across words with out-of-window widths
    t_duties            r_held, n_held;

    logic               out_free;   // result register can take a new word
    logic               advance;    // word moves from input to result register
    logic               in_accept;

    logic [WIDTH_W-1:0] steer_w, thr_w;
    t_link_dec          dec;
    t_duties            mix_duties;

    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min    <= PULSE_MIN_RST;
            r_cfg.pulse_max    <= PULSE_MAX_RST;
            r_cfg.fresh_window <= FRESH_WINDOW_RST;
            r_cfg.bad_limit    <= BAD_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_PULSE_MIN:    r_cfg.pulse_min    <= i_cfg_data[WIDTH_W-1:0];
                CFG_PULSE_MAX:    r_cfg.pulse_max    <= i_cfg_data[WIDTH_W-1:0];
                CFG_FRESH_WINDOW: r_cfg.fresh_window <= i_cfg_data[TIME_W-1:0];
                CFG_BAD_LIMIT:    r_cfg.bad_limit    <= i_cfg_data[COUNT_W-1:0];
                default:          r_cfg.bad_limit    <= r_cfg.bad_limit;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_now   <= i_now_us;
            r_in_steer <= i_steer_width_us;
            r_in_thr   <= i_throttle_width_us;
            r_in_fr    <= i_obstacle_front_right;
            r_in_fl    <= i_obstacle_front_left;
            r_in_rr    <= i_obstacle_rear_right;
            r_in_rl    <= i_obstacle_rear_left;
        end
    end

    // pulse capture and link health
    rcfs_link u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_now     (r_in_now),
        .i_steer_w (r_in_steer),
        .i_thr_w   (r_in_thr),
        .i_cfg     (r_cfg),
        .o_steer_w (steer_w),
        .o_thr_w   (thr_w),
        .o_dec     (dec)
    );

    // drive mixing on the held widths
    rcfs_mix u_mix (
        .i_steer_w (steer_w),
        .i_thr_w   (thr_w),
        .i_obst_fr (r_in_fr),
        .i_obst_fl (r_in_fl),
        .i_obst_rr (r_in_rr),
        .i_obst_rl (r_in_rl),
        .o_duties  (mix_duties)
    );

    // lost stops, driving takes the new mix, out-of-window widths keep the previous duties
    always_comb begin
        unique case (dec.status)
            LINK_LOST:  n_held = '0;
            LINK_DRIVE: n_held = mix_duties;
            LINK_HOLD:  n_held = r_held;
            default:    n_held = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (advance) begin
            r_held <= n_held;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_duties <= n_held;
            r_out_status <= dec.status;
            r_out_bad    <= dec.bad_run;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_left_forward_duty  = r_out_duties.left_fwd;
    assign o_left_reverse_duty  = r_out_duties.left_rev;
    assign o_right_forward_duty = r_out_duties.right_fwd;
    assign o_right_reverse_duty = r_out_duties.right_rev;
    assign o_link_status        = r_out_status;
    assign o_bad_run            = r_out_bad;

endmodule

`default_nettype wire

FILE: hw/rtl/rcfs_link.sv
// pulse capture, validity and freshness checks, bad word counter and link decision
`default_nettype none

module rcfs_link (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [rcfs_pkg::TIME_W-1:0]  i_now,
    input  wire logic [rcfs_pkg::WIDTH_W-1:0] i_steer_w,
    input  wire logic [rcfs_pkg::WIDTH_W-1:0] i_thr_w,
    input  wire rcfs_pkg::t_cfg               i_cfg,
    output logic      [rcfs_pkg::WIDTH_W-1:0] o_steer_w,
    output logic      [rcfs_pkg::WIDTH_W-1:0] o_thr_w,
    output rcfs_pkg::t_link_dec               o_dec
);
    import rcfs_pkg::*;

    localparam logic [COUNT_W-1:0] BAD_MAX = '1;

    logic [WIDTH_W-1:0] r_steer_w, n_steer_w;
    logic [TIME_W-1:0]  r_steer_t, n_steer_t;
    logic [WIDTH_W-1:0] r_thr_w, n_thr_w;
    logic [TIME_W-1:0]  r_thr_t, n_thr_t;
    logic [COUNT_W-1:0] r_bad, n_bad;

    logic [TIME_W-1:0] steer_age, thr_age;
    logic              steer_ok, thr_ok, steer_fresh, thr_fresh;
    logic              valid, fresh;

    always_comb begin
        // a zero width means no new pulse, keep the held one
        n_steer_w = (i_steer_w != '0) ? i_steer_w : r_steer_w;
        n_steer_t = (i_steer_w != '0) ? i_now : r_steer_t;
        n_thr_w   = (i_thr_w != '0) ? i_thr_w : r_thr_w;
        n_thr_t   = (i_thr_w != '0) ? i_now : r_thr_t;

        steer_ok = (n_steer_w >= i_cfg.pulse_min) && (n_steer_w <= i_cfg.pulse_max);
        thr_ok   = (n_thr_w >= i_cfg.pulse_min) && (n_thr_w <= i_cfg.pulse_max);

        // age wraps with the timestamp
        steer_age   = i_now - n_steer_t;
        thr_age     = i_now - n_thr_t;
        steer_fresh = steer_age <= i_cfg.fresh_window;
        thr_fresh   = thr_age <= i_cfg.fresh_window;

        valid = steer_ok && thr_ok;
        fresh = steer_fresh && thr_fresh;

        if (valid && fresh) begin
            n_bad = '0;
        end else if (r_bad != BAD_MAX) begin
            n_bad = r_bad + 1'b1;
        end else begin
            n_bad = r_bad;
        end

        priority if (!fresh || (n_bad > i_cfg.bad_limit)) begin
            o_dec.status = LINK_LOST;
        end else if (valid) begin
            o_dec.status = LINK_DRIVE;
        end else begin
            o_dec.status = LINK_HOLD;
        end
        o_dec.bad_run = n_bad;

        o_steer_w = n_steer_w;
        o_thr_w   = n_thr_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_w <= '0;
            r_steer_t <= '0;
            r_thr_w   <= '0;
            r_thr_t   <= '0;
            r_bad     <= '0;
        end else if (i_en) begin
            r_steer_w <= n_steer_w;
            r_steer_t <= n_steer_t;
            r_thr_w   <= n_thr_w;
            r_thr_t   <= n_thr_t;
            r_bad     <= n_bad;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rcfs_mix.sv
// deadband mapping to percent, tank mix, obstacle blocking and duty generation
`default_nettype none

module rcfs_mix (
    input  wire logic [rcfs_pkg::WIDTH_W-1:0] i_steer_w,
    input  wire logic [rcfs_pkg::WIDTH_W-1:0] i_thr_w,
    input  wire logic                         i_obst_fr,
    input  wire logic                         i_obst_fl,
    input  wire logic                         i_obst_rr,
    input  wire logic                         i_obst_rl,
    output rcfs_pkg::t_duties                 o_duties
);
    import rcfs_pkg::*;

    localparam logic [WIDTH_W-1:0] DB_HIGH   = 15'd1600;
    localparam logic [WIDTH_W-1:0] DB_LOW    = 15'd1400;
    // offset from the deadband edge at which the percent saturates
    localparam logic [WIDTH_W-1:0] SAT_SPAN  = 15'd300;
    localparam logic signed [7:0]  PCT_MAX   = 8'sd100;
    localparam logic signed [7:0]  PCT_MIN   = -8'sd100;
    localparam logic signed [8:0]  PCT_MAX_W = 9'sd100;
    localparam logic signed [8:0]  PCT_MIN_W = -9'sd100;
    // floor(x/3) = (x*683) >> 11 for x below the saturation span
    localparam logic [9:0]         RECIP3    = 10'd683;

    function automatic logic [6:0] div3(input logic [8:0] x);
        logic [18:0] prod;
        prod = x * RECIP3;
        return prod[17:11];
    endfunction

    function automatic logic signed [7:0] to_percent(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] d;
        logic signed [7:0]  p;
        p = '0;
        if (w > DB_HIGH) begin
            d = w - DB_HIGH;
            p = (d >= SAT_SPAN) ? PCT_MAX : $signed({1'b0, div3(d[8:0])});
        end else if (w < DB_LOW) begin
            d = DB_LOW - w;
            p = (d >= SAT_SPAN) ? PCT_MIN : -$signed({1'b0, div3(d[8:0])});
        end else begin
            d = '0;
        end
        return p;
    endfunction

    function automatic logic signed [7:0] clamp100(input logic signed [8:0] v);
        logic signed [7:0] c;
        if (v > PCT_MAX_W) begin
            c = PCT_MAX;
        end else if (v < PCT_MIN_W) begin
            c = PCT_MIN;
        end else begin
            c = v[7:0];
        end
        return c;
    endfunction

    function automatic logic [DUTY_W-1:0] fwd_duty(input logic signed [7:0] p);
        return (p > 8'sd0) ? {p[6:0], 1'b0} : '0;
    endfunction

    function automatic logic [DUTY_W-1:0] rev_duty(input logic signed [7:0] p);
        logic [7:0] m;
        m = 8'(-p);
        return (p < 8'sd0) ? {m[6:0], 1'b0} : '0;
    endfunction

    logic signed [7:0] thr_pct, steer_pct;
    logic signed [8:0] left_raw, right_raw;
    logic signed [7:0] left_c, right_c, left_f, right_f, left_p, right_p;

    always_comb begin
        thr_pct   = to_percent(i_thr_w);
        steer_pct = to_percent(i_steer_w);

        // steering sense flips when reversing
        if (!thr_pct[7]) begin
            left_raw  = 9'(thr_pct) + 9'(steer_pct);
            right_raw = 9'(thr_pct) - 9'(steer_pct);
        end else begin
            left_raw  = 9'(thr_pct) - 9'(steer_pct);
            right_raw = 9'(thr_pct) + 9'(steer_pct);
        end
        left_c  = clamp100(left_raw);
        right_c = clamp100(right_raw);

        // front obstacle blocks any forward motion
        if ((i_obst_fr || i_obst_fl) && ((left_c > 8'sd0) || (right_c > 8'sd0))) begin
            left_f  = '0;
            right_f = '0;
        end else begin
            left_f  = left_c;
            right_f = right_c;
        end

        // rear obstacle blocks any reverse motion
        if ((i_obst_rr || i_obst_rl) && ((left_f < 8'sd0) || (right_f < 8'sd0))) begin
            left_p  = '0;
            right_p = '0;
        end else begin
            left_p  = left_f;
            right_p = right_f;
        end

        o_duties.left_fwd  = fwd_duty(left_p);
        o_duties.left_rev  = rev_duty(left_p);
        o_duties.right_fwd = fwd_duty(right_p);
        o_duties.right_rev = rev_duty(right_p);
    end

endmodule

`default_nettype wire

FILE: bench/rc_failsafe_tank_drive_mixer_tb.sv
// self-checking testbench for the rc failsafe tank drive mixer: directed and random words
module rc_failsafe_tank_drive_mixer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rcfs_pkg::*;

    // obstacle flag positions in the packed obstacle nibble {fr, fl, rr, rl}
    localparam logic [3:0] OBS_NONE = 4'b0000;
    localparam logic [3:0] OBS_FR   = 4'b1000;
    localparam logic [3:0] OBS_FL   = 4'b0100;
    localparam logic [3:0] OBS_RR   = 4'b0010;
    localparam logic [3:0] OBS_RL   = 4'b0001;

    // deadband edges and percent scaling of a pulse width
    localparam int DEADBAND_HI = 1600;
    localparam int DEADBAND_LO = 1400;
    localparam int PCT_DIV     = 3;
    localparam int PCT_MAX     = 100;
    localparam int WIDTH_TOP   = 25000;
    localparam logic [COUNT_W-1:0] BAD_SAT = 8'd255;

    // one control word as offered on the input channel
    typedef struct packed {
        logic [TIME_W-1:0]  now_us;
        logic [WIDTH_W-1:0] steer_width;
        logic [WIDTH_W-1:0] throttle_width;
        logic [3:0]         obstacles;
    } t_ctrl_word;

    // one motor command word as expected on the output channel
    typedef struct packed {
        t_duties            duties;
        t_link_status       status;
        logic [COUNT_W-1:0] bad_run;
    } t_motor_word;

    logic                  i_clk                  = 1'b0;
    logic                  i_rst_n                = 1'b0;
    logic                  i_cfg_wr_en            = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx              = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data             = '0;
    logic                  i_valid                = 1'b0;
    logic                  o_stall;
    logic [TIME_W-1:0]     i_now_us               = '0;
    logic [WIDTH_W-1:0]    i_steer_width_us       = '0;
    logic [WIDTH_W-1:0]    i_throttle_width_us    = '0;
    logic                  i_obstacle_front_right = 1'b0;
    logic                  i_obstacle_front_left  = 1'b0;
    logic                  i_obstacle_rear_right  = 1'b0;
    logic                  i_obstacle_rear_left   = 1'b0;
    logic                  o_valid;
    logic                  i_stall                = 1'b0;
    logic [DUTY_W-1:0]     o_left_forward_duty;
    logic [DUTY_W-1:0]     o_left_reverse_duty;
    logic [DUTY_W-1:0]     o_right_forward_duty;
    logic [DUTY_W-1:0]     o_right_reverse_duty;
    logic [1:0]            o_link_status;
    logic [COUNT_W-1:0]    o_bad_run;

    // mirror of the configuration registers
    logic [WIDTH_W-1:0] cfg_pulse_min;
    logic [WIDTH_W-1:0] cfg_pulse_max;
    logic [TIME_W-1:0]  cfg_fresh_window;
    logic [COUNT_W-1:0] cfg_bad_limit;

    // mirror of the block's state
    logic [WIDTH_W-1:0] steer_held;
    logic [TIME_W-1:0]  steer_seen_us;
    logic [WIDTH_W-1:0] throttle_held;
    logic [TIME_W-1:0]  throttle_seen_us;
    logic [COUNT_W-1:0] bad_count;
    t_duties            duties_held;

    t_motor_word expected_motor[$];
    int          fail_count    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        rx_hold       = 1'b0;
    logic [TIME_W-1:0] stim_now = '0;

    rc_failsafe_tank_drive_mixer dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_now_us               (i_now_us),
        .i_steer_width_us       (i_steer_width_us),
        .i_throttle_width_us    (i_throttle_width_us),
        .i_obstacle_front_right (i_obstacle_front_right),
        .i_obstacle_front_left  (i_obstacle_front_left),
        .i_obstacle_rear_right  (i_obstacle_rear_right),
        .i_obstacle_rear_left   (i_obstacle_rear_left),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_left_forward_duty    (o_left_forward_duty),
        .o_left_reverse_duty    (o_left_reverse_duty),
        .o_right_forward_duty   (o_right_forward_duty),
        .o_right_reverse_duty   (o_right_reverse_duty),
        .o_link_status          (o_link_status),
        .o_bad_run              (o_bad_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // prediction
    // --------------------------------------------------------------------

    // pulse width to signed percent through the deadband, truncating toward zero
    function automatic int width_percent(input logic [WIDTH_W-1:0] w);
        int v;
        int p;
        v = w;
        p = 0;
        if (v > DEADBAND_HI) begin
            p = (v - DEADBAND_HI) / PCT_DIV;
            if (p > PCT_MAX) p = PCT_MAX;
        end
        if (v < DEADBAND_LO) begin
            p = (v - DEADBAND_LO) / PCT_DIV;
            if (p < -PCT_MAX) p = -PCT_MAX;
        end
        return p;
    endfunction

    function automatic int clamp_percent(input int v);
        if (v > PCT_MAX) return PCT_MAX;
        if (v < -PCT_MAX) return -PCT_MAX;
        return v;
    endfunction

    // update the mirrored state with one accepted word and queue the motor word it gives
    task automatic predict_motor(input t_ctrl_word w);
        logic [TIME_W-1:0] steer_age;
        logic [TIME_W-1:0] throttle_age;
        logic              widths_ok;
        logic              fresh;
        int                thr;
        int                str;
        int                lft;
        int                rgt;
        t_motor_word       m;
        // capture: a zero width means no pulse, the held one stays
        if (w.steer_width != '0) begin
            steer_held    = w.steer_width;
            steer_seen_us = w.now_us;
        end
        if (w.throttle_width != '0) begin
            throttle_held    = w.throttle_width;
            throttle_seen_us = w.now_us;
        end
        // ages wrap with the timestamp
        steer_age    = w.now_us - steer_seen_us;
        throttle_age = w.now_us - throttle_seen_us;
        fresh     = (steer_age <= cfg_fresh_window) && (throttle_age <= cfg_fresh_window);
        widths_ok = (steer_held >= cfg_pulse_min) && (steer_held <= cfg_pulse_max) &&
                    (throttle_held >= cfg_pulse_min) && (throttle_held <= cfg_pulse_max);
        if (widths_ok && fresh) begin
            bad_count = '0;
        end else if (bad_count != BAD_SAT) begin
            bad_count = bad_count + 1'b1;
        end
        if (!fresh || bad_count > cfg_bad_limit) begin
            // failsafe: stop and forget the last command
            duties_held = '0;
            m.status    = LINK_LOST;
        end else if (widths_ok) begin
            thr = width_percent(throttle_held);
            str = width_percent(steer_held);
            // steering sense flips when reversing
            if (thr >= 0) begin
                lft = thr + str;
                rgt = thr - str;
            end else begin
                lft = thr - str;
                rgt = thr + str;
            end
            lft = clamp_percent(lft);
            rgt = clamp_percent(rgt);
            if ((w.obstacles & (OBS_FR | OBS_FL)) != '0 && (lft > 0 || rgt > 0)) begin
                lft = 0;
                rgt = 0;
            end
            if ((w.obstacles & (OBS_RR | OBS_RL)) != '0 && (lft < 0 || rgt < 0)) begin
                lft = 0;
                rgt = 0;
            end
            duties_held.left_fwd  = (lft > 0) ? DUTY_W'(2 * lft) : '0;
            duties_held.left_rev  = (lft < 0) ? DUTY_W'(-2 * lft) : '0;
            duties_held.right_fwd = (rgt > 0) ? DUTY_W'(2 * rgt) : '0;
            duties_held.right_rev = (rgt < 0) ? DUTY_W'(-2 * rgt) : '0;
            m.status = LINK_DRIVE;
        end else begin
            // fresh but out of window: keep the previous duties
            m.status = LINK_HOLD;
        end
        m.duties  = duties_held;
        m.bad_run = bad_count;
        expected_motor.push_back(m);
    endtask

    task automatic reset_mirror();
        cfg_pulse_min    = PULSE_MIN_RST;
        cfg_pulse_max    = PULSE_MAX_RST;
        cfg_fresh_window = FRESH_WINDOW_RST;
        cfg_bad_limit    = BAD_LIMIT_RST;
        steer_held       = '0;
        steer_seen_us    = '0;
        throttle_held    = '0;
        throttle_seen_us = '0;
        bad_count        = '0;
        duties_held      = '0;
    endtask

    // --------------------------------------------------------------------
    // checking: words are sampled at the falling edge, ahead of the edge that takes them
    // --------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge i_clk) begin : check_motor
        t_motor_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_motor.size() == 0) begin
                $error("motor word with none expected: status %0d bad_run %0d",
                       o_link_status, o_bad_run);
                fail_count++;
            end else begin
                want = expected_motor.pop_front();
                check_field("left_forward_duty", want.duties.left_fwd, o_left_forward_duty);
                check_field("left_reverse_duty", want.duties.left_rev, o_left_reverse_duty);
                check_field("right_forward_duty", want.duties.right_fwd, o_right_forward_duty);
                check_field("right_reverse_duty", want.duties.right_rev, o_right_reverse_duty);
                check_field("link_status", int'(want.status), o_link_status);
                check_field("bad_run", want.bad_run, o_bad_run);
            end
        end
    end

    // receiver side: random stalls, or a solid hold-off while rx_hold is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= rx_hold || ($urandom_range(99) < stall_pct);
        end
    end

    // --------------------------------------------------------------------
    // stimulus helpers; all but hold_receiver start and end in the step of a rising edge
    // --------------------------------------------------------------------

    // offer one word, with random idle cycles ahead of it, and hold it until taken
    task automatic send_word(input t_ctrl_word w);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid                <= 1'b1;
        i_now_us               <= w.now_us;
        i_steer_width_us       <= w.steer_width;
        i_throttle_width_us    <= w.throttle_width;
        i_obstacle_front_right <= w.obstacles[3];
        i_obstacle_front_left  <= w.obstacles[2];
        i_obstacle_rear_right  <= w.obstacles[1];
        i_obstacle_rear_left   <= w.obstacles[0];
        taken = 1'b0;
        while (!taken) begin
            // o_stall is settled at the falling edge and holds through the next rising one
            @(negedge i_clk);
            taken = !o_stall;
            if (taken) predict_motor(w);
            @(posedge i_clk);
        end
    endtask

    function automatic t_ctrl_word make_word(input logic [TIME_W-1:0] now_us,
                                             input int steer, input int throttle,
                                             input logic [3:0] obstacles);
        t_ctrl_word w;
        w.now_us         = now_us;
        w.steer_width    = WIDTH_W'(steer);
        w.throttle_width = WIDTH_W'(throttle);
        w.obstacles      = obstacles;
        return w;
    endfunction

    // mostly plausible servo pulses, some gaps and some anywhere in range
    function automatic logic [WIDTH_W-1:0] pick_width();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 65) return WIDTH_W'($urandom_range(2000, 1000));
        if (pick < 90 && cfg_pulse_min <= cfg_pulse_max)
            return WIDTH_W'($urandom_range(cfg_pulse_max, cfg_pulse_min));
        return WIDTH_W'($urandom_range(WIDTH_TOP, 1));
    endfunction

    // timestamps mostly advance by up to 30 ms, sometimes jump far or anywhere
    function automatic t_ctrl_word next_word();
        int unsigned pick;
        t_ctrl_word  w;
        pick = $urandom_range(99);
        if (pick < 85) stim_now = stim_now + $urandom_range(30000, 1);
        else if (pick < 94) stim_now = stim_now + $urandom_range(250000, 30000);
        else stim_now = $urandom();
        w.now_us         = stim_now;
        w.steer_width    = pick_width();
        w.throttle_width = pick_width();
        w.obstacles[3]   = ($urandom_range(99) < 15);
        w.obstacles[2]   = ($urandom_range(99) < 15);
        w.obstacles[1]   = ($urandom_range(99) < 15);
        w.obstacles[0]   = ($urandom_range(99) < 15);
        return w;
    endfunction

    task automatic run_words(input int count);
        repeat (count) send_word(next_word());
    endtask

    // stop offering and wait for every motor word, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_motor.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // idling rates change at a falling edge so the stall process never races them;
    // the last word is withdrawn first so it is not taken twice
    task automatic set_idling(input int send_pct, input int rx_pct);
        i_valid <= 1'b0;
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        @(posedge i_clk);
    endtask

    // write all four registers back to back on an idle block
    task automatic set_config(input logic [WIDTH_W-1:0] pulse_min,
                              input logic [WIDTH_W-1:0] pulse_max,
                              input logic [TIME_W-1:0] fresh_window,
                              input logic [COUNT_W-1:0] bad_limit);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_PULSE_MIN;
        i_cfg_data  <= CFG_DATA_W'(pulse_min);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_PULSE_MAX;
        i_cfg_data  <= CFG_DATA_W'(pulse_max);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_FRESH_WINDOW;
        i_cfg_data  <= CFG_DATA_W'(fresh_window);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BAD_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(bad_limit);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_pulse_min    = pulse_min;
        cfg_pulse_max    = pulse_max;
        cfg_fresh_window = fresh_window;
        cfg_bad_limit    = bad_limit;
    endtask

    // receiver holds off for a counted stretch of cycles
    task automatic hold_receiver(input int cycles);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (cycles) @(negedge i_clk);
        rx_hold = 1'b0;
    endtask

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // reset defaults: deadband, truncation, mixing, obstacles, window edges, stale, wrap
    task automatic test_directed_mixing();
        set_idling(0, 0);
        send_word(make_word(32'd0, 0, 0, OBS_NONE));          // nothing held yet
        send_word(make_word(32'd100, 1500, 1500, OBS_NONE));  // centred sticks
        send_word(make_word(32'd200, 1500, 2000, OBS_NONE));  // full ahead, clamped
        send_word(make_word(32'd300, 0, 1000, OBS_NONE));     // full astern, steer held
        send_word(make_word(32'd400, 2000, 1500, OBS_NONE));  // spin on the spot
        send_word(make_word(32'd500, 1700, 1100, OBS_NONE));  // reversing with steer
        send_word(make_word(32'd600, 1399, 1603, OBS_NONE));  // truncation near deadband
        send_word(make_word(32'd700, 1396, 1600, OBS_NONE));
        send_word(make_word(32'd800, 1400, 1601, OBS_NONE));
        send_word(make_word(32'd900, 1500, 1800, OBS_FR));    // front blocks forward
        send_word(make_word(32'd1000, 1500, 1200, OBS_RL));   // rear blocks reverse
        send_word(make_word(32'd1100, 2000, 1500, OBS_FL | OBS_RR)); // spin, both sides
        send_word(make_word(32'd1200, 1500, 1200, OBS_FR));   // front ignored astern
        send_word(make_word(32'd1300, 999, 1500, OBS_NONE));  // below window: hold
        send_word(make_word(32'd1400, 2001, 1500, OBS_NONE)); // above window: hold
        send_word(make_word(32'd1500, WIDTH_TOP, WIDTH_TOP, OBS_NONE));
        send_word(make_word(32'd1600, 1000, 2000, OBS_NONE)); // exactly on the edges
        send_word(make_word(32'd101601, 0, 1500, OBS_NONE));  // steer one us too old
        send_word(make_word(32'd101602, 1500, 0, OBS_NONE));
        send_word(make_word(32'hFFFF_FF00, 1800, 1300, OBS_NONE));
        send_word(make_word(32'h0000_0050, 0, 0, OBS_NONE));  // ages across the wrap
        send_word(make_word(32'hFFFF_FFFF, 32'h7FFF & WIDTH_TOP, 1200, OBS_FR | OBS_RL));
        stim_now = 32'hFFFF_FFFF;
    endtask

    task automatic test_default_traffic();
        set_idling(0, 0);
        run_words(200);
    endtask

    // every width valid and nothing ever stale; high limit
    task automatic test_wide_window();
        set_config(15'd0, 15'(WIDTH_TOP), 32'hFFFF_FFFF, 8'd255);
        set_idling(63, 0);
        run_words(200);
    endtask

    // zero freshness and zero bad limit: any miss loses the link
    task automatic test_tight_window();
        set_config(15'd1100, 15'd1900, 32'd0, 8'd0);
        set_idling(0, 63);
        run_words(200);
    endtask

    // inverted window: nothing valid, bad count runs up to saturation
    task automatic test_inverted_window();
        set_config(15'(WIDTH_TOP), 15'd0, 32'd50000, 8'd255);
        set_idling(32, 32);
        run_words(280);
    endtask

    // back to defaults, then a long receiver hold-off while words keep coming
    task automatic test_receiver_hold_off();
        set_config(PULSE_MIN_RST, PULSE_MAX_RST, FRESH_WINDOW_RST, BAD_LIMIT_RST);
        set_idling(32, 32);
        run_words(150);
        set_idling(0, 0);
        fork
            hold_receiver(60);
            begin
                run_words(24);
                i_valid <= 1'b0;
            end
        join
        @(posedge i_clk);
    endtask

    initial begin
        reset_mirror();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_mixing();
        test_default_traffic();
        test_wide_window();
        test_tight_window();
        test_inverted_window();
        test_receiver_hold_off();
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("rc_failsafe_tank_drive_mixer_tb OK");
        end else begin
            $display("rc_failsafe_tank_drive_mixer_tb NOT OK");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("rc_failsafe_tank_drive_mixer_tb NOT OK");
        $finish;
    end

endmodule
